/* hw/rtl/srr_pkg.sv */
// shared constants and types for the selective repeat receiver
package srr_pkg;

    localparam int MAX_WINDOW_DEF  = 8;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int PKT_WORDS       = 5;
    localparam int PKT_BYTES       = 20;
    localparam int WORD_W          = 32;
    localparam int WIN_W           = 4;
    localparam int BSUM_W          = $clog2(PKT_BYTES * 255 + 1);
    localparam int WSUM_W          = $clog2(4 * 255 + 1);

    localparam logic [WIN_W-1:0] WINDOW_RESET = 4'd8;

    localparam logic KIND_ACK  = 1'b0;
    localparam logic KIND_DATA = 1'b1;

    typedef struct packed {
        logic [WORD_W-1:0]                seq;
        logic [PKT_WORDS-1:0][WORD_W-1:0] words;
    } pkt_t;

    typedef struct packed {
        logic                             result_kind;
        logic [WORD_W-1:0]                ack_number_out;
        logic [WORD_W-1:0]                ack_checksum;
        logic [PKT_WORDS-1:0][WORD_W-1:0] data;
        logic                             last_of_run;
    } result_t;

endpackage

/* hw/rtl/srr_if.sv */
// packet and result channel interfaces
interface srr_pkt_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] seq_number;
    logic signed [31:0] ack_number_in;
    logic signed [31:0] checksum_in;
    logic [31:0]        payload_w0;
    logic [31:0]        payload_w1;
    logic [31:0]        payload_w2;
    logic [31:0]        payload_w3;
    logic [31:0]        payload_w4;

    modport source (
        output valid, seq_number, ack_number_in, checksum_in,
        output payload_w0, payload_w1, payload_w2, payload_w3, payload_w4,
        input  ready
    );
    modport sink (
        input  valid, seq_number, ack_number_in, checksum_in,
        input  payload_w0, payload_w1, payload_w2, payload_w3, payload_w4,
        output ready
    );
endinterface

interface srr_res_if;
    logic               valid;
    logic               ready;
    logic               result_kind;
    logic signed [31:0] ack_number_out;
    logic signed [31:0] ack_checksum;
    logic [31:0]        data_w0;
    logic [31:0]        data_w1;
    logic [31:0]        data_w2;
    logic [31:0]        data_w3;
    logic [31:0]        data_w4;
    logic               last_of_run;

    modport source (
        output valid, result_kind, ack_number_out, ack_checksum,
        output data_w0, data_w1, data_w2, data_w3, data_w4, last_of_run,
        input  ready
    );
    modport sink (
        input  valid, result_kind, ack_number_out, ack_checksum,
        input  data_w0, data_w1, data_w2, data_w3, data_w4, last_of_run,
        output ready
    );
endinterface

/* hw/rtl/srr_front.sv */
// front end: packet capture and checksum screening
module srr_front (
    input  logic          clk,
    input  logic          rst_n,
    srr_pkt_if.sink       packet,
    output logic          q_valid,
    input  logic          q_ready,
    output srr_pkg::pkt_t q_pkt
);
    import srr_pkg::*;

    logic              stg_valid_reg;
    pkt_t              stg_pkt_reg;
    logic [WORD_W-1:0] stg_part_reg;
    logic [BSUM_W-1:0] stg_bytes_reg;
    logic [WORD_W-1:0] stg_chk_reg;

    pkt_t              in_pkt;
    logic [BSUM_W-1:0] byte_sum;
    logic              good;
    logic              stg_leave;

    always_comb
    begin
        in_pkt.seq      = $unsigned(packet.seq_number);
        in_pkt.words[0] = packet.payload_w0;
        in_pkt.words[1] = packet.payload_w1;
        in_pkt.words[2] = packet.payload_w2;
        in_pkt.words[3] = packet.payload_w3;
        in_pkt.words[4] = packet.payload_w4;
    end

    // per-word byte sums first, then the five partials
    always_comb
    begin
        logic [WSUM_W-1:0] wsum [PKT_WORDS];
        byte_sum = '0;
        for (int k = 0; k < PKT_WORDS; k++)
        begin
            wsum[k] = '0;
            for (int b = 0; b < 4; b++)
            begin
                wsum[k] = wsum[k] + WSUM_W'(in_pkt.words[k][8*b +: 8]);
            end
        end
        for (int k = 0; k < PKT_WORDS; k++)
        begin
            byte_sum = byte_sum + BSUM_W'(wsum[k]);
        end
    end

    assign good      = (stg_part_reg + WORD_W'(stg_bytes_reg)) == stg_chk_reg;
    assign q_valid   = stg_valid_reg && good;
    assign q_pkt     = stg_pkt_reg;
    assign stg_leave = stg_valid_reg && (!good || q_ready);
    assign packet.ready = !stg_valid_reg || stg_leave;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
        end
        else if (packet.ready)
        begin
            stg_valid_reg <= packet.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (packet.valid && packet.ready)
        begin
            stg_pkt_reg   <= in_pkt;
            stg_part_reg  <= $unsigned(packet.seq_number) + $unsigned(packet.ack_number_in);
            stg_bytes_reg <= byte_sum;
            stg_chk_reg   <= $unsigned(packet.checksum_in);
        end
    end

endmodule

/* hw/rtl/srr_fifo.sv */
// short queue between front and back
module srr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             push;
    logic             pop;

    assign in_ready  = count_reg != CW'(DEPTH);
    assign out_valid = count_reg != '0;
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

/* hw/rtl/srr_back.sv */
// back end: window classification, reorder buffer and result sequencing
module srr_back #(
    parameter int MAX_WINDOW = srr_pkg::MAX_WINDOW_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [srr_pkg::WIN_W-1:0] window_size,
    input  logic                     q_valid,
    output logic                     q_ready,
    input  srr_pkg::pkt_t            q_pkt,
    srr_res_if.source                result
);
    import srr_pkg::*;

    localparam int SW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam logic [WORD_W-1:0] MAXW = WORD_W'(MAX_WINDOW);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLASS,
        S_ACK,
        S_DATA,
        S_DRAIN
    } state_t;

    state_t                           state_reg;
    pkt_t                             pkt_reg;
    logic                             expected_reg;
    logic [WORD_W-1:0]                next_expected_reg;
    logic [SW-1:0]                    head_reg;
    logic [SW-1:0]                    head_next;
    logic [SW-1:0]                    drain_cnt_reg;
    logic [MAX_WINDOW-1:0]            slot_valid_reg;
    logic                             out_valid_reg;
    result_t                          out_reg;

    logic [PKT_WORDS-1:0][WORD_W-1:0] slot_mem [MAX_WINDOW];
    logic [PKT_WORDS-1:0][WORD_W-1:0] rdata_reg;

    logic [WIN_W-1:0]                 w_eff;
    logic [WORD_W-1:0]                fwd;
    logic [WORD_W-1:0]                bwd;
    logic                             in_win;
    logic                             prev_win;
    logic [SW:0]                      slot_sum;
    logic [SW-1:0]                    slot_idx;
    logic                             mem_we;
    logic [SW-1:0]                    head_inc;
    logic                             out_free;
    logic                             deliver_load;
    logic                             out_load;
    logic                             data_more;
    logic                             drain_more;

    always_comb
    begin
        w_eff = window_size;
        if (window_size == '0)
        begin
            w_eff = WIN_W'(1);
        end
        else if (WORD_W'(window_size) > MAXW)
        begin
            w_eff = MAXW[WIN_W-1:0];
        end
    end

    // distances modulo 2^32 so the window follows the sequence wrap
    assign fwd      = pkt_reg.seq - next_expected_reg;
    assign bwd      = next_expected_reg - pkt_reg.seq;
    assign in_win   = fwd < WORD_W'(w_eff);
    assign prev_win = (bwd != '0) && (bwd <= WORD_W'(w_eff));

    always_comb
    begin
        slot_sum = {1'b0, head_reg} + {1'b0, fwd[SW-1:0]};
        if (slot_sum >= (SW+1)'(MAX_WINDOW))
        begin
            slot_sum = slot_sum - (SW+1)'(MAX_WINDOW);
        end
        slot_idx = slot_sum[SW-1:0];
    end

    assign mem_we = (state_reg == S_CLASS) && in_win && (fwd != '0)
                    && !slot_valid_reg[slot_idx];

    assign head_inc     = (head_reg == SW'(MAX_WINDOW - 1)) ? '0 : head_reg + 1'b1;
    assign out_free     = !out_valid_reg || result.ready;
    assign deliver_load = ((state_reg == S_DATA) || (state_reg == S_DRAIN)) && out_free;
    assign out_load     = ((state_reg == S_ACK) && out_free) || deliver_load;
    assign head_next    = deliver_load ? head_inc : head_reg;

    // the run never goes past one lap of the ring
    assign data_more  = slot_valid_reg[head_inc] && (MAX_WINDOW > 1);
    assign drain_more = slot_valid_reg[head_inc]
                        && ((32'(drain_cnt_reg) + 32'd1) < 32'(MAX_WINDOW - 1));

    assign q_ready = state_reg == S_IDLE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            expected_reg      <= 1'b0;
            next_expected_reg <= '0;
            head_reg          <= '0;
            drain_cnt_reg     <= '0;
            slot_valid_reg    <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            head_reg <= head_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        pkt_reg   <= q_pkt;
                        state_reg <= S_CLASS;
                    end
                end
                S_CLASS:
                begin
                    expected_reg <= in_win && (fwd == '0);
                    if (mem_we)
                    begin
                        slot_valid_reg[slot_idx] <= 1'b1;
                    end
                    state_reg <= (in_win || prev_win) ? S_ACK : S_IDLE;
                end
                S_ACK:
                begin
                    if (out_free)
                    begin
                        out_reg.result_kind    <= KIND_ACK;
                        out_reg.ack_number_out <= pkt_reg.seq;
                        out_reg.ack_checksum   <= pkt_reg.seq;
                        out_reg.data           <= '0;
                        out_reg.last_of_run    <= !expected_reg;
                        state_reg              <= expected_reg ? S_DATA : S_IDLE;
                    end
                end
                S_DATA:
                begin
                    if (out_free)
                    begin
                        out_reg.result_kind    <= KIND_DATA;
                        out_reg.ack_number_out <= '0;
                        out_reg.ack_checksum   <= '0;
                        out_reg.data           <= pkt_reg.words;
                        out_reg.last_of_run    <= !data_more;
                        next_expected_reg      <= next_expected_reg + 1'b1;
                        drain_cnt_reg          <= '0;
                        state_reg              <= data_more ? S_DRAIN : S_IDLE;
                    end
                end
                S_DRAIN:
                begin
                    if (out_free)
                    begin
                        out_reg.result_kind      <= KIND_DATA;
                        out_reg.ack_number_out   <= '0;
                        out_reg.ack_checksum     <= '0;
                        out_reg.data             <= rdata_reg;
                        out_reg.last_of_run      <= !drain_more;
                        slot_valid_reg[head_reg] <= 1'b0;
                        next_expected_reg        <= next_expected_reg + 1'b1;
                        drain_cnt_reg            <= drain_cnt_reg + 1'b1;
                        state_reg                <= drain_more ? S_DRAIN : S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // read follows the head so the buffered word is ready on entry to drain
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[slot_idx] <= pkt_reg.words;
        end
        rdata_reg <= slot_mem[head_next];
    end

    assign result.valid          = out_valid_reg;
    assign result.result_kind    = out_reg.result_kind;
    assign result.ack_number_out = $signed(out_reg.ack_number_out);
    assign result.ack_checksum   = $signed(out_reg.ack_checksum);
    assign result.data_w0        = out_reg.data[0];
    assign result.data_w1        = out_reg.data[1];
    assign result.data_w2        = out_reg.data[2];
    assign result.data_w3        = out_reg.data[3];
    assign result.data_w4        = out_reg.data[4];
    assign result.last_of_run    = out_reg.last_of_run;

    // the head slot is empty except while its buffered word is being drained
    a_head_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_DRAIN) |-> !slot_valid_reg[head_reg])
        else $error("head slot marked valid outside a drain");

    a_drain_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRAIN) |-> slot_valid_reg[head_reg])
        else $error("drain reached an empty slot");

    a_expected_moves: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(next_expected_reg) |-> $past(deliver_load))
        else $error("next expected moved without a delivery");

    a_run_open: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.last_of_run) |-> (state_reg != S_IDLE))
        else $error("back end idle in the middle of a run");

endmodule

/* hw/rtl/selective_repeat_receiver.sv */
// selective repeat receiver top level
// Usage: packets come in on the packet channel, one packet per accepted
// handshake (sequence, ack field, checksum, five payload words). Results
// leave on the result channel: acks (kind 0) and deliveries (kind 1), with
// last_of_run set on the final result a packet causes. cfg_we/cfg_wdata
// write the window size; write it only while the block is idle.
// The front stage screens the checksum, one packet per cycle while the queue
// has room; it drops corrupt packets and sends good ones through a two-entry
// queue to the back end. The back end takes a new packet only when idle: it
// classifies it, sends an ack if it lies in the window or the one before,
// and for an in-order packet delivers it and the buffered packets that it
// releases, one result per cycle while the result channel is not stalled.
// The reorder buffer is one row of five words per slot in a memory with a
// registered read port that tracks the window head.
// Reset clears the window base, the head and the slot valid flags at once,
// and sets the window to 8; there is no clearing pass.
// A stalled result channel holds the output register; the back end waits
// and the queue and front stage keep accepting until they fill.
module selective_repeat_receiver #(
    parameter int MAX_WINDOW  = srr_pkg::MAX_WINDOW_DEF,
    parameter int QUEUE_DEPTH = srr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [srr_pkg::WIN_W-1:0] cfg_wdata,
    srr_pkt_if.sink                   packet,
    srr_res_if.source                 result
);
    import srr_pkg::*;

    logic [WIN_W-1:0] window_size_reg;
    logic             fq_valid;
    logic             fq_ready;
    pkt_t             fq_pkt;
    logic             qb_valid;
    logic             qb_ready;
    pkt_t             qb_pkt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= WINDOW_RESET;
        end
        else if (cfg_we)
        begin
            window_size_reg <= cfg_wdata;
        end
    end

    srr_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .packet  (packet),
        .q_valid (fq_valid),
        .q_ready (fq_ready),
        .q_pkt   (fq_pkt)
    );

    srr_fifo #(
        .WIDTH ($bits(pkt_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_pkt),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_pkt)
    );

    srr_back #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .window_size (window_size_reg),
        .q_valid     (qb_valid),
        .q_ready     (qb_ready),
        .q_pkt       (qb_pkt),
        .result      (result)
    );

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps
// self-checking testbench for the selective repeat receiver, with a packet-level predictor
module testbench;

    import srr_pkg::*;

    localparam int SLOTS       = MAX_WINDOW_DEF;
    localparam int SETTLE      = 20;
    localparam int CYCLE_LIMIT = 200000;

    typedef logic [PKT_WORDS-1:0][WORD_W-1:0] words_t;

    typedef struct packed {
        logic [WORD_W-1:0] seq;
        logic [WORD_W-1:0] ackn;
        logic [WORD_W-1:0] chk;
        words_t            words;
    } packet_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [WIN_W-1:0] cfg_wdata;

    srr_pkt_if packet_bus ();
    srr_res_if result_bus ();

    selective_repeat_receiver u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .packet    (packet_bus),
        .result    (result_bus)
    );

    // receiver state as the predictor sees it
    logic [WIN_W-1:0]  win_reg = WINDOW_RESET;
    logic [WORD_W-1:0] rx_base = '0;
    int                rx_head = 0;
    logic              slot_full [SLOTS];
    words_t            slot_words [SLOTS];

    packet_t packets_to_send [$];
    result_t due_results [$];
    packet_t tx_pkt;
    int      packets_queued = 0;
    int      packets_taken  = 0;
    int      n_errors       = 0;
    int      cycle_count    = 0;
    bit      steady         = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [WORD_W-1:0] checksum_of(input logic [WORD_W-1:0] seq,
                                                     input logic [WORD_W-1:0] ackn,
                                                     input words_t words);
        logic [WORD_W-1:0] sum;
        int i;
        int b;
        sum = seq + ackn;
        for (i = 0; i < PKT_WORDS; i++)
            for (b = 0; b < 4; b++)
                sum += {24'd0, words[i][8*b +: 8]};
        return sum;
    endfunction

    function automatic words_t random_words();
        words_t w;
        int i;
        for (i = 0; i < PKT_WORDS; i++)
            w[i] = $urandom;
        return w;
    endfunction

    function automatic result_t ack_result(input logic [WORD_W-1:0] seq);
        result_t r;
        r = '0;
        r.result_kind    = KIND_ACK;
        r.ack_number_out = seq;
        r.ack_checksum   = seq;
        return r;
    endfunction

    function automatic result_t delivery_result(input words_t words);
        result_t r;
        r = '0;
        r.result_kind = KIND_DATA;
        r.data        = words;
        return r;
    endfunction

    // works out the acks and deliveries one accepted packet causes
    task automatic predict_packet(input packet_t p);
        result_t           run_out [$];
        result_t           r;
        logic [WORD_W-1:0] w;
        logic [WORD_W-1:0] fwd;
        logic [WORD_W-1:0] back;
        int                s;
        int                i;
        if (checksum_of(p.seq, p.ackn, p.words) != p.chk)
            return;
        if (win_reg == 0)
            w = 1;
        else if (win_reg > SLOTS)
            w = SLOTS;
        else
            w = {28'd0, win_reg};
        fwd  = p.seq - rx_base;
        back = rx_base - p.seq;
        if (fwd < w)
        begin
            run_out = {run_out, ack_result(p.seq)};
            if (fwd == 0)
            begin
                run_out = {run_out, delivery_result(p.words)};
                rx_base++;
                rx_head = (rx_head + 1) % SLOTS;
                for (i = 1; i < SLOTS && slot_full[rx_head]; i++)
                begin
                    run_out = {run_out, delivery_result(slot_words[rx_head])};
                    slot_full[rx_head] = 1'b0;
                    rx_base++;
                    rx_head = (rx_head + 1) % SLOTS;
                end
            end
            else
            begin
                s = (rx_head + int'(fwd)) % SLOTS;
                // a duplicate leaves the first stored copy alone
                if (!slot_full[s])
                begin
                    slot_full[s]  = 1'b1;
                    slot_words[s] = p.words;
                end
            end
        end
        else if (back >= 1 && back <= w)
            run_out = {run_out, ack_result(p.seq)};
        else
            return;
        r = run_out.pop_back();
        r.last_of_run = 1'b1;
        run_out = {run_out, r};
        due_results = {due_results, run_out};
    endtask

    task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
        if (got !== want)
        begin
            n_errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    task automatic queue_packet(input logic [WORD_W-1:0] seq, input logic [WORD_W-1:0] ackn,
                                input words_t words, input bit corrupt);
        packet_t p;
        p.seq   = seq;
        p.ackn  = ackn;
        p.words = words;
        p.chk   = checksum_of(seq, ackn, words);
        if (corrupt)
            p.chk ^= 32'd1 << $urandom_range(0, 31);
        packets_to_send = {packets_to_send, p};
        packets_queued++;
    endtask

    // all packets taken and every result in, then let dropped packets clear the pipe
    task automatic wait_idle();
        do
            @(negedge clk);
        while (packets_taken != packets_queued || due_results.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_window(input logic [WIN_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    task automatic directed_phase();
        int s;
        write_window(4'd8);
        queue_packet(32'd0, 32'd0, '0, 1'b0);
        queue_packet(32'd1, 32'hFFFF_FFFF, random_words(), 1'b1);
        // out of order, then a duplicate with other payload
        queue_packet(32'd2, 32'h7FFF_FFFF, '1, 1'b0);
        queue_packet(32'd2, 32'h8000_0000, random_words(), 1'b0);
        // previous window, across the sequence wrap, and just beyond it
        queue_packet(32'd0, $urandom, random_words(), 1'b0);
        queue_packet(32'hFFFF_FFFF, $urandom, random_words(), 1'b0);
        queue_packet(32'hFFFF_FFF9, $urandom, random_words(), 1'b0);
        queue_packet(32'hFFFF_FFF8, $urandom, random_words(), 1'b0);
        // first seq past the window, then the last one inside it
        queue_packet(32'd9, $urandom, random_words(), 1'b0);
        queue_packet(32'd8, $urandom, random_words(), 1'b0);
        queue_packet(32'h8000_0000, $urandom, random_words(), 1'b0);
        queue_packet(32'h7FFF_FFFF, $urandom, random_words(), 1'b0);
        queue_packet(32'd1, 32'hFFFF_FFFF, '1, 1'b0);
        // sender holds off until everything has come out
        wait_idle();
        for (s = 7; s >= 3; s--)
            queue_packet(s, $urandom, random_words(), 1'b0);
        for (s = 10; s <= 16; s++)
            queue_packet(s, $urandom, random_words(), 1'b0);
        // releases the seven buffered packets behind it, a full window in all
        queue_packet(32'd9, $urandom, random_words(), 1'b0);
        wait_idle();
        // shrink the window with a packet still buffered
        queue_packet(32'd20, $urandom, random_words(), 1'b0);
        wait_idle();
        write_window(4'd2);
        for (s = 17; s <= 19; s++)
            queue_packet(s, $urandom, random_words(), 1'b0);
        wait_idle();
    endtask

    task automatic random_phase(input logic [WIN_W-1:0] win_code, input int target);
        logic [WORD_W-1:0] gen_base;
        logic [WORD_W-1:0] w;
        int                order [SLOTS];
        int                made;
        int                k;
        int                j;
        int                tmp;
        int                r;
        write_window(win_code);
        if (win_code == 0)
            w = 1;
        else if (win_code > SLOTS)
            w = SLOTS;
        else
            w = {28'd0, win_code};
        gen_base = rx_base;
        made = 0;
        while (made < target)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
            begin
                // a whole window in shuffled order, with corrupt copies and repeats
                for (k = 0; k < int'(w); k++)
                    order[k] = k;
                for (k = int'(w) - 1; k > 0; k--)
                begin
                    j = $urandom_range(0, k);
                    tmp = order[k];
                    order[k] = order[j];
                    order[j] = tmp;
                end
                for (k = 0; k < int'(w); k++)
                begin
                    if ($urandom_range(0, 99) < 15)
                        queue_packet(gen_base + order[k], $urandom, random_words(), 1'b1);
                    queue_packet(gen_base + order[k], $urandom, random_words(), 1'b0);
                    made++;
                    if ($urandom_range(0, 99) < 10)
                    begin
                        queue_packet(gen_base + order[k], $urandom, random_words(), 1'b0);
                        made++;
                    end
                end
                gen_base += w;
            end
            else if (r < 85)
            begin
                queue_packet(gen_base - $urandom_range(1, int'(w)), $urandom, random_words(),
                             1'b0);
                made++;
            end
            else if (r < 93)
                queue_packet($urandom, $urandom, random_words(), 1'b1);
            else if (r < 97)
            begin
                if ($urandom_range(0, 1) == 1)
                    queue_packet(gen_base + w + $urandom_range(0, 3), $urandom, random_words(),
                                 1'b0);
                else
                    queue_packet(gen_base - w - 1 - $urandom_range(0, 3), $urandom,
                                 random_words(), 1'b0);
            end
            else
                queue_packet($urandom, $urandom, random_words(), 1'b0);
        end
        wait_idle();
    endtask

    // packet driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            packet_bus.valid <= 1'b0;
        else if (!packet_bus.valid || packet_bus.ready)
        begin
            if (packets_to_send.size() != 0 && (steady || $urandom_range(0, 99) >= 23))
            begin
                tx_pkt = packets_to_send.pop_front();
                packet_bus.valid         <= 1'b1;
                packet_bus.seq_number    <= tx_pkt.seq;
                packet_bus.ack_number_in <= tx_pkt.ackn;
                packet_bus.checksum_in   <= tx_pkt.chk;
                packet_bus.payload_w0    <= tx_pkt.words[0];
                packet_bus.payload_w1    <= tx_pkt.words[1];
                packet_bus.payload_w2    <= tx_pkt.words[2];
                packet_bus.payload_w3    <= tx_pkt.words[3];
                packet_bus.payload_w4    <= tx_pkt.words[4];
            end
            else
                packet_bus.valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_bus.ready <= 1'b0;
        else
            result_bus.ready <= steady || ($urandom_range(0, 99) >= 23);
    end

    // monitor: checks each result word and predicts from each accepted packet
    always @(posedge clk)
    begin : monitor_proc
        packet_t rx_pkt;
        result_t want;
        words_t  got_data;
        int      i;
        if (rst_n)
        begin
            if (cfg_we)
                win_reg = cfg_wdata;
            if (result_bus.valid && result_bus.ready)
            begin
                if (due_results.size() == 0)
                begin
                    n_errors++;
                    $display("%0t: unexpected result, expected none, actual kind %0d ack %h",
                             $time, result_bus.result_kind, result_bus.ack_number_out);
                end
                else
                begin
                    want = due_results.pop_front();
                    got_data = {result_bus.data_w4, result_bus.data_w3, result_bus.data_w2,
                                result_bus.data_w1, result_bus.data_w0};
                    check_field("result_kind", {31'd0, want.result_kind},
                                {31'd0, result_bus.result_kind});
                    check_field("ack_number_out", want.ack_number_out,
                                result_bus.ack_number_out);
                    check_field("ack_checksum", want.ack_checksum, result_bus.ack_checksum);
                    for (i = 0; i < PKT_WORDS; i++)
                        check_field($sformatf("data_w%0d", i), want.data[i], got_data[i]);
                    check_field("last_of_run", {31'd0, want.last_of_run},
                                {31'd0, result_bus.last_of_run});
                end
            end
            if (packet_bus.valid && packet_bus.ready)
            begin
                rx_pkt.seq   = packet_bus.seq_number;
                rx_pkt.ackn  = packet_bus.ack_number_in;
                rx_pkt.chk   = packet_bus.checksum_in;
                rx_pkt.words = {packet_bus.payload_w4, packet_bus.payload_w3,
                                packet_bus.payload_w2, packet_bus.payload_w1,
                                packet_bus.payload_w0};
                packets_taken++;
                predict_packet(rx_pkt);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin : main_proc
        int i;
        clk       = 1'b0;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        packet_bus.valid         = 1'b0;
        packet_bus.seq_number    = '0;
        packet_bus.ack_number_in = '0;
        packet_bus.checksum_in   = '0;
        packet_bus.payload_w0    = '0;
        packet_bus.payload_w1    = '0;
        packet_bus.payload_w2    = '0;
        packet_bus.payload_w3    = '0;
        packet_bus.payload_w4    = '0;
        result_bus.ready         = 1'b0;
        for (i = 0; i < SLOTS; i++)
        begin
            slot_full[i]  = 1'b0;
            slot_words[i] = '0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        directed_phase();
        random_phase(4'd1, 14);
        random_phase(4'd0, 12);
        steady = 1'b1;
        random_phase(4'd15, 16);
        steady = 1'b0;
        random_phase(4'd3, 14);
        random_phase(4'd9, 16);
        random_phase(4'd5, 14);
        random_phase(4'd8, 16);

        if (n_errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/srr_pkg.sv
hw/rtl/srr_if.sv
hw/rtl/srr_front.sv
hw/rtl/srr_fifo.sv
hw/rtl/srr_back.sv
hw/rtl/selective_repeat_receiver.sv
sim/testbench.sv
